// ===== hdl/dq_pkg.sv =====
// Shared definitions for the double-ended queue: field widths, operation and
// status codes, and the control word that steers the chain of storage cells.
// No dependencies.
package dq_pkg;

    localparam int WORD_W    = 32;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 5;
    localparam int DEPTH_DEF = 16;

    // Operation codes carried by an input item.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd5;

    // Status codes carried by a result item.
    localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_MATCH    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_LISTED   = 3'd5;

    // Movement of the whole chain, applied to all cells at once.
    typedef struct packed {
        logic shift_up;   // every cell takes its lower neighbor's word
        logic shift_dn;   // every cell takes its upper neighbor's word
    } t_chain_ctl;

endpackage

// ===== hdl/double_ended_queue.sv =====
// Bounded double-ended queue built as a ring of storage cells plus its controller.
// Depends on dq_pkg and dq_cell.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | to block  | i_in_valid / o_in_ready   | i_kind, i_operand_word
//  out     | from block| o_out_valid / i_out_ready | o_status, o_result_word, o_position,
//          |           |                           | o_final_res
//
// Push front, push back, pop front, unknown kinds and every operation that only
// reports empty or full are finished as they are taken. Pop back, search and dump
// walk one full rotation of the cell ring through cell 0, where the word is read;
// search then gives its closing result from a finish state.
// A stalled output freezes the rotation; a new item is taken only when the
// controller is idle and the output register is free or being emptied.
// Reset (synchronous, active low) empties the deque; the cells keep their words.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [KIND_W-1:0]          i_kind,
    input  logic signed [WORD_W-1:0]   i_operand_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [WORD_W-1:0]   o_result_word,
    output logic [POS_W-1:0]           o_position,
    output logic                       o_final_res
);

    localparam int AW = $clog2(DEPTH);        // step through the ring
    localparam int CW = $clog2(DEPTH + 1);    // fill level 0..DEPTH

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

    // The ring of cells. Outside a walk, cell 0 holds the front word, and the words
    // follow in order up to cell r_count-1, which holds the back word.
    logic [WORD_W-1:0] cell_word [DEPTH];
    t_chain_ctl        chain_ctl;
    logic              load_front;
    logic              load_back;

    t_state              r_state,     n_state;
    logic [CW-1:0]       r_count,     n_count;
    logic [AW-1:0]       r_step,      n_step;
    logic [KIND_W-1:0]   r_kind,      n_kind;
    logic [WORD_W-1:0]   r_key,       n_key;
    logic                r_pend_v,    n_pend_v;
    logic [WORD_W-1:0]   r_pend_word, n_pend_word;
    logic [POS_W-1:0]    r_pend_pos,  n_pend_pos;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_stat,  n_out_stat;
    logic [WORD_W-1:0]   r_out_word,  n_out_word;
    logic [POS_W-1:0]    r_out_pos,   n_out_pos;
    logic                r_out_final, n_out_final;

    logic              out_free;
    logic              in_acc;
    logic              is_full;
    logic              is_empty;
    logic [WORD_W-1:0] head;
    logic [CW-1:0]     pos_full;
    logic [POS_W-1:0]  pos_cur;
    logic              in_range;
    logic              step_last;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            dq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (chain_ctl),
                .i_load    ((load_front && (g == 0)) || (load_back && (r_count == CW'(g)))),
                .i_operand (i_operand_word),
                .i_from_lo (cell_word[(g + DEPTH - 1) % DEPTH]),
                .i_from_hi (cell_word[(g + 1) % DEPTH]),
                .o_word    (cell_word[g])
            );
        end
    endgenerate

    // The output register is free when empty or when its item leaves this cycle.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign head      = cell_word[0];

    // During a walk, cell 0 holds the word at position r_step+1 from the front.
    assign pos_full  = CW'(r_step) + CW'(1);
    assign pos_cur   = POS_W'(pos_full);
    assign in_range  = (CW'(r_step) < r_count);
    assign step_last = (r_step == AW'(DEPTH - 1));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_kind      = r_kind;
        n_key       = r_key;
        n_pend_v    = r_pend_v;
        n_pend_word = r_pend_word;
        n_pend_pos  = r_pend_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_stat  = r_out_stat;
        n_out_word  = r_out_word;
        n_out_pos   = r_out_pos;
        n_out_final = r_out_final;
        chain_ctl   = '0;
        load_front  = 1'b0;
        load_back   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_kind) inside
                        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            n_out_word  = '0;
                            n_out_pos   = '0;
                            n_out_final = 1'b1;
                            if (is_full) begin
                                n_out_stat = STAT_FULL;
                            end else begin
                                n_out_stat = STAT_DONE;
                                n_count    = r_count + CW'(1);
                                if (i_kind == KIND_PUSH_FRONT) begin
                                    chain_ctl.shift_up = 1'b1;
                                    load_front         = 1'b1;
                                end else begin
                                    load_back = 1'b1;
                                end
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_BACK, KIND_DUMP: begin
                            if (is_empty) begin
                                n_out_valid = 1'b1;
                                n_out_stat  = STAT_EMPTY;
                                n_out_word  = '0;
                                n_out_pos   = '0;
                                n_out_final = 1'b1;
                            end else if (i_kind == KIND_POP_FRONT) begin
                                n_out_valid        = 1'b1;
                                n_out_stat         = STAT_DONE;
                                n_out_word         = head;
                                n_out_pos          = '0;
                                n_out_final        = 1'b1;
                                n_count            = r_count - CW'(1);
                                chain_ctl.shift_dn = 1'b1;
                            end else begin
                                n_state = S_WALK;
                                n_kind  = i_kind;
                                n_step  = '0;
                            end
                        end
                        KIND_SEARCH: begin
                            n_state  = S_WALK;
                            n_kind   = i_kind;
                            n_key    = i_operand_word;
                            n_step   = '0;
                            n_pend_v = 1'b0;
                        end
                        default: begin
                            // Unused kinds are taken and cause no result.
                        end
                    endcase
                end
            end

            S_WALK: begin
                if (out_free) begin
                    chain_ctl.shift_dn = 1'b1;
                    n_step             = r_step + AW'(1);
                    case (r_kind)
                        KIND_POP_BACK: begin
                            if (pos_full == r_count) begin
                                n_out_valid = 1'b1;
                                n_out_stat  = STAT_DONE;
                                n_out_word  = head;
                                n_out_pos   = '0;
                                n_out_final = 1'b1;
                            end
                        end
                        KIND_DUMP: begin
                            if (in_range) begin
                                n_out_valid = 1'b1;
                                n_out_stat  = STAT_LISTED;
                                n_out_word  = head;
                                n_out_pos   = pos_cur;
                                n_out_final = (pos_full == r_count);
                            end
                        end
                        default: begin
                            // Search: hold each match back one step so the
                            // last one can carry the final flag.
                            if (in_range && (head == r_key)) begin
                                if (r_pend_v) begin
                                    n_out_valid = 1'b1;
                                    n_out_stat  = STAT_MATCH;
                                    n_out_word  = r_pend_word;
                                    n_out_pos   = r_pend_pos;
                                    n_out_final = 1'b0;
                                end
                                n_pend_v    = 1'b1;
                                n_pend_word = head;
                                n_pend_pos  = pos_cur;
                            end
                        end
                    endcase
                    if (step_last) begin
                        n_step = '0;
                        if (r_kind == KIND_SEARCH) begin
                            n_state = S_FINISH;
                        end else begin
                            n_state = S_IDLE;
                        end
                        if (r_kind == KIND_POP_BACK) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_final = 1'b1;
                    if (r_pend_v) begin
                        n_out_stat = STAT_MATCH;
                        n_out_word = r_pend_word;
                        n_out_pos  = r_pend_pos;
                    end else begin
                        n_out_stat = STAT_NOTFOUND;
                        n_out_word = '0;
                        n_out_pos  = '0;
                    end
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
        r_kind      <= n_kind;
        r_key       <= n_key;
        r_pend_word <= n_pend_word;
        r_pend_pos  <= n_pend_pos;
        r_out_stat  <= n_out_stat;
        r_out_word  <= n_out_word;
        r_out_pos   <= n_out_pos;
        r_out_final <= n_out_final;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_stat;
    assign o_result_word = r_out_word;
    assign o_position    = r_out_pos;
    assign o_final_res   = r_out_final;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill level exceeds the ring size");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("new item taken while a walk is in progress");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_full && (i_kind == KIND_PUSH_FRONT || i_kind == KIND_PUSH_BACK))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted push did not grow the deque");

    a_pend_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("held search match left over after the search");

    a_walk_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_WALK) |-> (r_step == '0))
        else $error("ring rotation left unfinished");
`endif

endmodule

// ===== hdl/dq_cell.sv =====
// One storage cell of the deque chain: holds a word and moves it to a
// neighbor, or loads the operand, as the chain control says.
// Depends on dq_pkg.
module dq_cell
    import dq_pkg::*;
(
    input  logic              i_clk,
    input  t_chain_ctl        i_ctl,
    input  logic              i_load,
    input  logic [WORD_W-1:0] i_operand,
    input  logic [WORD_W-1:0] i_from_lo,
    input  logic [WORD_W-1:0] i_from_hi,
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    // A load wins over movement so that a push front can shift and insert at once.
    always_comb begin
        if (i_load) begin
            n_word = i_operand;
        end else if (i_ctl.shift_up) begin
            n_word = i_from_lo;
        end else if (i_ctl.shift_dn) begin
            n_word = i_from_hi;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule
